[rtl/latency_percentile_select_unit_assert.svh]
// Assertion macros shared by the percentile select unit.
// Each macro takes a label, clock, reset, a condition, a check and a message.
`ifndef LATENCY_PERCENTILE_SELECT_UNIT_ASSERT_SVH
`define LATENCY_PERCENTILE_SELECT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LPSEL_ASSERT_IMP(lbl, clk, rst, cond, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
    else $error(msg);
`define LPSEL_ASSERT_NXT(lbl, clk, rst, cond, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
    else $error(msg);
`else
`define LPSEL_ASSERT_IMP(lbl, clk, rst, cond, chk, msg)
`define LPSEL_ASSERT_NXT(lbl, clk, rst, cond, chk, msg)
`endif

`endif

[rtl/lpsel_pkg.sv]
package lpsel_pkg;

  // Sample store geometry
  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int DATA_W      = 64;

  // Configuration register widths
  localparam int LIMIT_W   = 11;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_SET_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LIMIT      = 2'd2;

  // Reset values
  localparam logic [LIMIT_W-1:0] SMALL_SET_LIMIT_RST = 11'd100;
  localparam logic [PCT_W-1:0]   PERCENT_RST         = 7'd99;
  localparam logic [DATA_W-1:0]  WARN_LIMIT_RST      = 64'd1000000;

  // Rank arithmetic: floor(n * percent / 100) by reciprocal multiply.
  // ceil(2^32 / 100) is exact for products below 2^30.
  localparam int PROD_W      = CNT_W + PCT_W;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 32;
  localparam int FULL_W      = PROD_W + RECIP_W;
  localparam int QUOT_W      = FULL_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = 26'd42949673;

  // Request from the batch front end to the selection engine
  typedef struct packed {
    logic              start;
    logic              take;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] max;
  } sel_req_t;

  // Response from the selection engine
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] value;
  } sel_resp_t;

endpackage

[rtl/lpsel_ram.sv]
module lpsel_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/lpsel_select.sv]
`include "latency_percentile_select_unit_assert.svh"

module lpsel_select
  import lpsel_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  sel_req_t           req,
  input  logic [LIMIT_W-1:0] small_set_limit,
  input  logic [PCT_W-1:0]   percent,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [DATA_W-1:0]  rd_data,
  output sel_resp_t          resp
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PROD  = 9'b000000010,
    S_QUOT  = 9'b000000100,
    S_CLAMP = 9'b000001000,
    S_CAND  = 9'b000010000,
    S_LOAD  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_EVAL  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  n_reg;
  logic [DATA_W-1:0] max_reg;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [FULL_W-1:0] full;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  less;
  logic [CNT_W-1:0]  leq;
  logic [DATA_W-1:0] cand;
  logic [DATA_W-1:0] value;
  logic              is_lt;
  logic              is_le;

  assign full  = FULL_W'(prod) * FULL_W'(RECIP);
  assign is_lt = rd_data < cand;
  assign is_le = rd_data <= cand;

  // Read address: the candidate, then a sweep over the batch
  always_comb begin
    case (state)
      S_CAND:  rd_addr = i[ADDR_W-1:0];
      S_SCAN:  rd_addr = j[ADDR_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  // Sequencer: rank, then count smaller and not-greater samples per candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            n_reg   <= req.count;
            max_reg <= req.max;
            if (req.count == '0) begin
              value <= '0;
              state <= S_DONE;
            end else if (CMP_W'(req.count) < CMP_W'(small_set_limit)) begin
              value <= req.max;
              state <= S_DONE;
            end else begin
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          prod  <= PROD_W'(n_reg) * PROD_W'(percent);
          state <= S_QUOT;
        end
        S_QUOT: begin
          quot  <= full[FULL_W-1:RECIP_SHIFT];
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (quot >= QUOT_W'(n_reg)) begin
            k <= n_reg - CNT_W'(1);
          end else begin
            k <= quot[CNT_W-1:0];
          end
          i     <= '0;
          state <= S_CAND;
        end
        S_CAND: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          cand  <= rd_data;
          j     <= CNT_W'(1);
          less  <= '0;
          leq   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // rd_data holds the sample at j - 1
          less <= less + CNT_W'(is_lt);
          leq  <= leq + CNT_W'(is_le);
          if (j == n_reg) begin
            state <= S_EVAL;
          end else begin
            j <= j + CNT_W'(1);
          end
        end
        S_EVAL: begin
          if (less <= k && k < leq) begin
            value <= cand;
            state <= S_DONE;
          end else if (i == n_reg - CNT_W'(1)) begin
            value <= max_reg;
            state <= S_DONE;
          end else begin
            i     <= i + CNT_W'(1);
            state <= S_CAND;
          end
        end
        S_DONE: begin
          if (req.take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign resp.busy  = state != S_IDLE;
  assign resp.done  = state == S_DONE;
  assign resp.value = value;

  `LPSEL_ASSERT_IMP(a_start_idle, clk, rst, req.start, state == S_IDLE, "start while busy")
  `LPSEL_ASSERT_IMP(a_scan_range, clk, rst, state == S_SCAN, (j != '0) && (j <= n_reg), "scan index out of batch")
  `LPSEL_ASSERT_IMP(a_eval_counts, clk, rst, state == S_EVAL, (less <= leq) && (leq <= n_reg), "rank counts inconsistent")
  `LPSEL_ASSERT_NXT(a_rank_clamped, clk, rst, state == S_CLAMP, k < n_reg, "rank not below sample count")

endmodule

[rtl/latency_percentile_select_unit.sv]
// Latency percentile selector.
// Input channel (in_valid / in_stall): one 64-bit duration per item; is_last
// closes the batch. Samples load into the store one per cycle unless stalled;
// once it holds MAX_SAMPLES entries further samples are dropped and not counted.
// After the last item the input stalls while the result is worked out:
//   - fewer samples than small_set_limit: the running maximum (zero if empty);
//   - otherwise the sample at rank floor(n * percent / 100), clamped to n - 1.
//     Candidates are tried in turn, at most n, each with a sweep of the batch
//     over the single store read port.
// Output channel (out_valid / out_stall): one result per batch with the value,
// the sample count and over_limit (value above warn_limit). The result sits in
// an output register; a stalled receiver holds it, and a finished search then
// waits in the engine, keeping the input stalled, until the register frees.
// Configuration (cfg_write / cfg_index / cfg_data) must be written only while
// idle; the block does not enforce this. Reset empties the batch and restores
// register defaults but not the store; only entries below the count are read.
module latency_percentile_select_unit
  import lpsel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    duration,
  input  logic                 is_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    percentile_value,
  output logic [LIMIT_W-1:0]   sample_count,
  output logic                 over_limit
);

  logic [LIMIT_W-1:0] small_set_limit;
  logic [PCT_W-1:0]   percent;
  logic [DATA_W-1:0]  warn_limit;
  logic [CNT_W-1:0]   stored_count;
  logic [DATA_W-1:0]  running_max;
  logic [CNT_W-1:0]   batch_n;
  logic               start_pending;
  logic               in_acc;
  logic               has_room;
  logic               take;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DATA_W-1:0]  rd_data;
  sel_req_t           req;
  sel_resp_t          resp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      small_set_limit <= SMALL_SET_LIMIT_RST;
      percent         <= PERCENT_RST;
      warn_limit      <= WARN_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SMALL_SET_LIMIT: small_set_limit <= cfg_data[LIMIT_W-1:0];
        REG_PERCENT:         percent         <= cfg_data[PCT_W-1:0];
        REG_WARN_LIMIT:      warn_limit      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = resp.busy | start_pending;
  assign in_acc   = in_valid & ~in_stall;
  assign has_room = stored_count < CNT_W'(MAX_SAMPLES);

  // Batch front end: append samples, track the maximum, close on the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      running_max   <= '0;
      start_pending <= 1'b0;
    end else if (start_pending) begin
      start_pending <= 1'b0;
      stored_count  <= '0;
      running_max   <= '0;
    end else if (in_acc) begin
      if (has_room) begin
        stored_count <= stored_count + CNT_W'(1);
        if (stored_count == '0 || duration > running_max) begin
          running_max <= duration;
        end
      end
      if (is_last) begin
        start_pending <= 1'b1;
        batch_n       <= has_room ? stored_count + CNT_W'(1) : stored_count;
      end
    end
  end

  lpsel_ram #(
    .DEPTH  (MAX_SAMPLES),
    .WIDTH  (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_acc & has_room),
    .wr_addr (stored_count[ADDR_W-1:0]),
    .wr_data (duration),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign take = resp.done & (~out_valid | ~out_stall);

  assign req.start = start_pending;
  assign req.take  = take;
  assign req.count = batch_n;
  assign req.max   = running_max;

  lpsel_select u_select (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .small_set_limit (small_set_limit),
    .percent         (percent),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .resp            (resp)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      percentile_value <= resp.value;
      sample_count     <= batch_n[LIMIT_W-1:0];
      over_limit       <= resp.value > warn_limit;
    end
  end

endmodule
